/* hw/rtl/maets_pkg.sv */
`timescale 1ns / 1ps

package maets_pkg;

  // Default sizing of the point stores and coordinate precision
  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int MAX_COVERED_DEF    = 64;
  localparam int COORD_BITS_DEF     = 16;

  // Fixed widths of the item fields
  localparam int PORT_COORD_W = 16;
  localparam int AREA_OUT_W   = 33;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_CAND = 2'd1,
    OP_ADD_COV  = 2'd2,
    OP_SEARCH   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_FEW   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

/* hw/rtl/min_area_enclosing_triangle_search.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// command   in         cmd_valid/cmd_stall opcode, point_x, point_y
// result    out        res_valid/res_stall status, first/second/third x/y, double_area
//
// Clear and point loads finish without leaving the idle state; a load into a full store
// and a search with too few candidates report through the report state. A search of N
// candidates and M covered points tries up to C(N,3) triples: every cross product, one
// per triple for the area and up to three per covered point, goes through the one shared multiplier.
// Synchronous active-high reset empties both stores; nothing is swept.
// A pending result never blocks loads; only a new result waits for the output slot.
module min_area_enclosing_triangle_search
  import maets_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
  parameter int MAX_COVERED    = MAX_COVERED_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [1:0]                     opcode,
  input  logic signed [PORT_COORD_W-1:0] point_x,
  input  logic signed [PORT_COORD_W-1:0] point_y,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [1:0]                     status,
  output logic signed [PORT_COORD_W-1:0] first_x,
  output logic signed [PORT_COORD_W-1:0] first_y,
  output logic signed [PORT_COORD_W-1:0] second_x,
  output logic signed [PORT_COORD_W-1:0] second_y,
  output logic signed [PORT_COORD_W-1:0] third_x,
  output logic signed [PORT_COORD_W-1:0] third_y,
  output logic [AREA_OUT_W-1:0]          double_area
);

  localparam int CW   = COORD_BITS;
  localparam int XW   = 2 * (CW + 1) + 1;     // signed cross product
  localparam int AW   = 2 * CW + 2;           // magnitude of the cross product
  localparam int CIW  = $clog2(MAX_CANDIDATES);
  localparam int CCW  = $clog2(MAX_CANDIDATES + 1);
  localparam int QIW  = (MAX_COVERED > 1) ? $clog2(MAX_COVERED) : 1;
  localparam int QCW  = $clog2(MAX_COVERED + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REPORT,
    S_FA,
    S_FB,
    S_FC,
    S_FD,
    S_AREA_GO,
    S_AREA_WAIT,
    S_AREA_CMP,
    S_QRD,
    S_QLD,
    S_EDGE_GO,
    S_EDGE_WAIT,
    S_NEXT
  } state_t;

  // Which cross product the shared unit is working on
  typedef enum logic [1:0] {
    X_AREA,
    X_E1,
    X_E2,
    X_E3
  } xsel_t;

  state_t state;
  xsel_t  xsel;

  // Store bookkeeping
  logic [CCW-1:0] cand_count;
  logic [QCW-1:0] cov_count;

  // Search indices and working points
  logic [CIW-1:0]         ci, ck, cl;
  logic [QIW-1:0]         q;
  logic signed [CW-1:0]   pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pq_x, pq_y;
  logic [AW-1:0]          area;
  logic                   anyneg, anypos;

  // Best triple so far
  logic                   have;
  logic [AW-1:0]          best;
  logic signed [CW-1:0]   ba_x, ba_y, bb_x, bb_y, bc_x, bc_y;
  status_t                rep_status;

  // Memory ports
  logic                   cand_we, cov_we;
  logic [CIW-1:0]         cand_raddr;
  logic [2*CW-1:0]        cand_wdata, cand_rdata, cov_rdata;

  // Shared unit
  logic                   xstart, xdone;
  logic signed [CW-1:0]   xo_x, xo_y, xa_x, xa_y, xb_x, xb_y;
  logic signed [XW-1:0]   xcross;
  logic [XW-1:0]          xmag;
  logic                   xneg, xpos, mixed;

  logic                   cmd_fire, out_free;
  opcode_t                op;
  logic signed [CW-1:0]   in_x, in_y;
  logic [CCW-1:0]         l_inc, k_inc2, i_inc3;
  logic [QCW-1:0]         q_inc;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign op        = opcode_t'(opcode);

  // Coordinates narrower than the port keep their low bits; wider ones sign-extend
  assign in_x       = CW'(point_x);
  assign in_y       = CW'(point_y);
  assign cand_wdata = {in_y, in_x};

  assign cand_we = cmd_fire && (op == OP_ADD_CAND) && (cand_count != CCW'(MAX_CANDIDATES));
  assign cov_we  = cmd_fire && (op == OP_ADD_COV) && (cov_count != QCW'(MAX_COVERED));

  always_comb begin
    unique case (state)
      S_FA:    cand_raddr = ci;
      S_FB:    cand_raddr = ck;
      default: cand_raddr = cl;
    endcase
  end

  maets_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_CANDIDATES)
  ) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (cand_count[CIW-1:0]),
    .wdata (cand_wdata),
    .raddr (cand_raddr),
    .rdata (cand_rdata)
  );

  maets_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_COVERED)
  ) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_count[QIW-1:0]),
    .wdata (cand_wdata),
    .raddr (q),
    .rdata (cov_rdata)
  );

  // Operand routing: area is (b - a) x (c - a); edges are (b - a) x (q - a)
  // around a, b, c in turn
  always_comb begin
    unique case (xsel)
      X_AREA: begin
        xo_x = pa_x; xo_y = pa_y; xa_x = pb_x; xa_y = pb_y; xb_x = pc_x; xb_y = pc_y;
      end
      X_E1: begin
        xo_x = pa_x; xo_y = pa_y; xa_x = pb_x; xa_y = pb_y; xb_x = pq_x; xb_y = pq_y;
      end
      X_E2: begin
        xo_x = pb_x; xo_y = pb_y; xa_x = pc_x; xa_y = pc_y; xb_x = pq_x; xb_y = pq_y;
      end
      X_E3: begin
        xo_x = pc_x; xo_y = pc_y; xa_x = pa_x; xa_y = pa_y; xb_x = pq_x; xb_y = pq_y;
      end
    endcase
  end

  assign xstart = (state == S_AREA_GO) || (state == S_EDGE_GO);

  maets_cross #(
    .COORD_BITS (CW)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .start     (xstart),
    .o_x       (xo_x),
    .o_y       (xo_y),
    .a_x       (xa_x),
    .a_y       (xa_y),
    .b_x       (xb_x),
    .b_y       (xb_y),
    .done      (xdone),
    .cross_val (xcross)
  );

  assign xneg  = xcross[XW-1];
  assign xpos  = !xneg && (xcross != '0);
  assign xmag  = xneg ? $unsigned(-xcross) : $unsigned(xcross);
  // A covered point fails once it has seen both a strict left and a strict right turn
  assign mixed = (anyneg || xneg) && (anypos || xpos);

  assign l_inc  = CCW'(cl) + CCW'(1);
  assign k_inc2 = CCW'(ck) + CCW'(2);
  assign i_inc3 = CCW'(ci) + CCW'(3);
  assign q_inc  = QCW'(q) + QCW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      cand_count <= '0;
      cov_count  <= '0;
    end else begin
      // The report step raises the slot itself when it frees up
      if (res_valid && !res_stall && (state != S_REPORT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            unique case (op)
              OP_CLEAR: begin
                cand_count <= '0;
                cov_count  <= '0;
              end
              OP_ADD_CAND: begin
                if (cand_we) begin
                  cand_count <= cand_count + CCW'(1);
                end else begin
                  rep_status <= ST_FULL;
                  state      <= S_REPORT;
                end
              end
              OP_ADD_COV: begin
                if (cov_we) begin
                  cov_count <= cov_count + QCW'(1);
                end else begin
                  rep_status <= ST_FULL;
                  state      <= S_REPORT;
                end
              end
              OP_SEARCH: begin
                if (cand_count < CCW'(3)) begin
                  rep_status <= ST_FEW;
                  state      <= S_REPORT;
                end else begin
                  have  <= 1'b0;
                  ci    <= CIW'(0);
                  ck    <= CIW'(1);
                  cl    <= CIW'(2);
                  state <= S_FA;
                end
              end
            endcase
          end
        end
        S_REPORT: begin
          // Hold until the output slot frees up
          if (out_free) begin
            res_valid <= 1'b1;
            status    <= rep_status;
            if (rep_status == ST_FOUND) begin
              first_x     <= PORT_COORD_W'(ba_x);
              first_y     <= PORT_COORD_W'(ba_y);
              second_x    <= PORT_COORD_W'(bb_x);
              second_y    <= PORT_COORD_W'(bb_y);
              third_x     <= PORT_COORD_W'(bc_x);
              third_y     <= PORT_COORD_W'(bc_y);
              double_area <= AREA_OUT_W'(best);
            end else begin
              first_x     <= '0;
              first_y     <= '0;
              second_x    <= '0;
              second_y    <= '0;
              third_x     <= '0;
              third_y     <= '0;
              double_area <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_FA: begin
          state <= S_FB;
        end
        S_FB: begin
          {pa_y, pa_x} <= cand_rdata;
          state        <= S_FC;
        end
        S_FC: begin
          {pb_y, pb_x} <= cand_rdata;
          state        <= S_FD;
        end
        S_FD: begin
          {pc_y, pc_x} <= cand_rdata;
          xsel         <= X_AREA;
          state        <= S_AREA_GO;
        end
        S_AREA_GO: begin
          state <= S_AREA_WAIT;
        end
        S_AREA_WAIT: begin
          if (xdone) begin
            area  <= AW'(xmag);
            state <= S_AREA_CMP;
          end
        end
        S_AREA_CMP: begin
          // Drop triples that cannot beat the best; ties keep the earlier one
          if (have && (area >= best)) begin
            state <= S_NEXT;
          end else if (cov_count == '0) begin
            have  <= 1'b1;
            best  <= area;
            ba_x  <= pa_x; ba_y <= pa_y;
            bb_x  <= pb_x; bb_y <= pb_y;
            bc_x  <= pc_x; bc_y <= pc_y;
            state <= S_NEXT;
          end else begin
            q     <= '0;
            state <= S_QRD;
          end
        end
        S_QRD: begin
          state <= S_QLD;
        end
        S_QLD: begin
          {pq_y, pq_x} <= cov_rdata;
          anyneg       <= 1'b0;
          anypos       <= 1'b0;
          xsel         <= X_E1;
          state        <= S_EDGE_GO;
        end
        S_EDGE_GO: begin
          state <= S_EDGE_WAIT;
        end
        S_EDGE_WAIT: begin
          if (xdone) begin
            anyneg <= anyneg || xneg;
            anypos <= anypos || xpos;
            if (mixed) begin
              state <= S_NEXT;
            end else if (xsel != X_E3) begin
              xsel  <= (xsel == X_E1) ? X_E2 : X_E3;
              state <= S_EDGE_GO;
            end else if (q_inc < cov_count) begin
              q     <= QIW'(q_inc);
              state <= S_QRD;
            end else begin
              have  <= 1'b1;
              best  <= area;
              ba_x  <= pa_x; ba_y <= pa_y;
              bb_x  <= pb_x; bb_y <= pb_y;
              bc_x  <= pc_x; bc_y <= pc_y;
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          // Advance i < k < l in index order
          priority if (l_inc < cand_count) begin
            cl    <= CIW'(l_inc);
            state <= S_FA;
          end else if (k_inc2 < cand_count) begin
            ck    <= ck + CIW'(1);
            cl    <= CIW'(k_inc2);
            state <= S_FA;
          end else if (i_inc3 < cand_count) begin
            ci    <= ci + CIW'(1);
            ck    <= ci + CIW'(2);
            cl    <= CIW'(i_inc3);
            state <= S_FA;
          end else begin
            rep_status <= have ? ST_FOUND : ST_NONE;
            state      <= S_REPORT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The shared unit only answers while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    xdone |-> (state == S_AREA_WAIT || state == S_EDGE_WAIT))
    else $error("cross unit finished outside a wait state");

  // Triple indices stay ordered and inside the loaded candidates during a search
  a_triple_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FA || state == S_AREA_CMP || state == S_EDGE_WAIT || state == S_NEXT) |->
      (ci < ck && ck < cl && CCW'(cl) < cand_count))
    else $error("search indices out of order");

  // Anything but a found triangle carries zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_FOUND) |->
      (first_x == '0 && third_y == '0 && double_area == '0))
    else $error("non-found result carries payload");

  // A result appears only after the report step
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_REPORT)
    else $error("result raised outside report step");

endmodule

/* hw/rtl/maets_ram.sv */
`timescale 1ns / 1ps

module maets_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/maets_cross.sv */
`timescale 1ns / 1ps

// Shared cross-product unit: (a - o) x (b - o), one multiplier used twice.
// Operands are sampled on start; the result shows with done once start has passed s1, s2 and s3.
module maets_cross
  import maets_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int XW = PW + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] o_x,
  input  logic signed [COORD_BITS-1:0] o_y,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  output logic                         done,
  output logic signed [XW-1:0]         cross_val
);

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [DW-1:0] mul_l, mul_r;
  logic signed [PW-1:0] prod, first;
  logic                 s1, s2, s3;

  // First pass takes dax * dby, second pass day * dbx
  assign mul_l = s1 ? dax : day;
  assign mul_r = s1 ? dby : dbx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      s3   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= start;
      s2   <= s1;
      s3   <= s2;
      done <= s3;
    end
    if (start) begin
      dax <= DW'(a_x) - DW'(o_x);
      day <= DW'(a_y) - DW'(o_y);
      dbx <= DW'(b_x) - DW'(o_x);
      dby <= DW'(b_y) - DW'(o_y);
    end
    if (s1 || s2) begin
      prod <= mul_l * mul_r;
    end
    if (s2) begin
      first <= prod;
    end
    if (s3) begin
      cross_val <= XW'(first) - XW'(prod);
    end
  end

endmodule
